// ===== design/wsp_pkg.sv =====
`default_nettype none
package wsp_pkg;

  // chunk and header identifiers, little-endian as read from the stream
  localparam logic [31:0] ID_FMT  = 32'h20746D66;
  localparam logic [31:0] ID_DATA = 32'h61746164;
  localparam logic [31:0] ID_RIFF = 32'h46464952;
  localparam logic [31:0] ID_WAVE = 32'h45564157;

  localparam int unsigned FMT_BYTES = 16;

  typedef enum logic [3:0] {
    PH_RIFF_ID,
    PH_RIFF_SIZE,
    PH_RIFF_TYPE,
    PH_CHUNK_ID,
    PH_CHUNK_SZ,
    PH_FMT_BODY,
    PH_SKIP,
    PH_SAMPLES,
    PH_ERROR,
    PH_DONE,
    PH_DIV
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_RIFF_ID    = 4'd0,
    ERR_TYPE       = 4'd1,
    ERR_COMP       = 4'd2,
    ERR_ZERO_CHANS = 4'd3,
    ERR_NOT_MONO   = 4'd4,
    ERR_ALIGN_ZERO = 4'd5,
    ERR_BITS_LOW   = 4'd6,
    ERR_BITS_HIGH  = 4'd7,
    ERR_ALIGN_MISM = 4'd8,
    ERR_DATA_EARLY = 4'd9,
    ERR_SIZE_MULT  = 4'd10,
    ERR_TRUNCATED  = 4'd11
  } err_t;

  // controller to datapath
  typedef struct packed {
    logic  restart;
    logic  shift_word;
    logic  latch_id;
    logic  load_skip_fmt;
    logic  load_skip_pad;
    logic  skip_dec;
    logic  fmt_write;
    logic  fmt_commit;
    logic  div_start;
    logic  sample_add;
    logic  sample_clear;
    logic  out_load;
    kind_t out_kind;
    err_t  out_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic word_last;
    logic fmt_last;
    logic is_riff;
    logic is_wave;
    logic id_fmt;
    logic id_data;
    logic padded_zero;
    logic fmt_bad;
    err_t fmt_code;
    logic skip_last;
    logic skip_zero;
    logic format_seen;
    logic sample_last;
    logic div_idle;
    logic div_rem_zero;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/wsp_in_if.sv =====
`default_nettype none
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  logic       end_of_stream;

  modport source (output valid, data_byte, restart, end_of_stream, input ready);
  modport sink (input valid, data_byte, restart, end_of_stream, output ready);
endinterface
`default_nettype wire

// ===== design/wsp_out_if.sv =====
`default_nettype none
interface wsp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] sample;
  logic [31:0]        sample_rate;
  logic [6:0]         valid_bits;
  logic [3:0]         sample_bytes;
  logic [31:0]        frame_count;
  logic [3:0]         error_code;

  modport source (output valid, kind, sample, sample_rate, valid_bits, sample_bytes,
                  frame_count, error_code, input ready);
  modport sink (input valid, kind, sample, sample_rate, valid_bits, sample_bytes,
                frame_count, error_code, output ready);
endinterface
`default_nettype wire

// ===== design/wsp_dpath.sv =====
`default_nettype none
module wsp_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        data_byte,
  input  wire wsp_pkg::cmd_t     cmd,
  output wsp_pkg::sts_t          sts,
  output logic [1:0]             o_kind,
  output logic signed [31:0]     o_sample,
  output logic [31:0]            o_rate,
  output logic [6:0]             o_bits,
  output logic [3:0]             o_bytes,
  output logic [31:0]            o_frames,
  output logic [3:0]             o_err
);

  logic [3:0]  cnt_r, cnt_nxt, cnt_e;
  logic [31:0] word_r, word_nxt, word_new;
  logic [31:0] id_r, id_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [7:0]  body_r [wsp_pkg::FMT_BYTES];
  logic        seen_r, seen_nxt;
  logic [31:0] rate_r, rate_nxt, rate_e;
  logic [6:0]  bits_r, bits_nxt, bits_e;
  logic [3:0]  bytes_r, bytes_nxt, bytes_e;
  logic [31:0] acc_r, acc_nxt, acc_sum, acc_add, smp_v;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] padded;
  logic [15:0] f_comp, f_chans, f_align, f_bits;
  logic [31:0] f_rate;
  logic [16:0] f_bits_rnd;
  logic        div_busy_r, div_busy_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [4:0]  div_try;
  logic        div_ge;

  // restart beat sees the reset view of the counters and format
  assign cnt_e    = cmd.restart ? 4'd0 : cnt_r;
  assign rate_e   = cmd.restart ? 32'd0 : rate_r;
  assign bits_e   = cmd.restart ? 7'd0 : bits_r;
  assign bytes_e  = cmd.restart ? 4'd0 : bytes_r;
  assign word_new = {data_byte, word_r[31:8]};
  assign padded   = word_new + {31'd0, word_new[0]};

  // fmt body fields, last byte straight from the input
  assign f_comp     = {body_r[1], body_r[0]};
  assign f_chans    = {body_r[3], body_r[2]};
  assign f_rate     = {body_r[7], body_r[6], body_r[5], body_r[4]};
  assign f_align    = {body_r[13], body_r[12]};
  assign f_bits     = {data_byte, body_r[14]};
  assign f_bits_rnd = ({1'b0, f_bits} + 17'd7) >> 3;

  // sample byte, the top byte sign-extended for samples of two to four bytes
  always_comb begin
    smp_v = {24'd0, data_byte};
    if (sts.sample_last && bytes_r >= 4'd2 && data_byte[7]) begin
      smp_v = {24'hFFFFFF, data_byte};
    end
    acc_add = 32'd0;
    if (idx_r < 3'd4) begin
      acc_add = smp_v << {idx_r[1:0], 3'b000};
    end
    acc_sum = acc_r + acc_add;
  end

  // status
  always_comb begin
    sts              = '0;
    sts.word_last    = (cnt_e[1:0] == 2'd3);
    sts.fmt_last     = (cnt_e == 4'd15);
    sts.is_riff      = (word_new == wsp_pkg::ID_RIFF);
    sts.is_wave      = (word_new == wsp_pkg::ID_WAVE);
    sts.id_fmt       = (id_r == wsp_pkg::ID_FMT);
    sts.id_data      = (id_r == wsp_pkg::ID_DATA);
    sts.padded_zero  = (padded == 32'd0);
    sts.skip_last    = (skip_r == 32'd1);
    sts.skip_zero    = (skip_r == 32'd0);
    sts.format_seen  = seen_r;
    sts.sample_last  = ({1'b0, idx_r} + 4'd1 >= bytes_r);
    sts.div_idle     = !div_busy_r;
    sts.div_rem_zero = (rem_r == 4'd0);
    sts.fmt_bad      = 1'b1;
    if (f_comp != 16'd1) begin
      sts.fmt_code = wsp_pkg::ERR_COMP;
    end else if (f_chans == 16'd0) begin
      sts.fmt_code = wsp_pkg::ERR_ZERO_CHANS;
    end else if (f_chans != 16'd1) begin
      sts.fmt_code = wsp_pkg::ERR_NOT_MONO;
    end else if (f_align == 16'd0) begin
      sts.fmt_code = wsp_pkg::ERR_ALIGN_ZERO;
    end else if (f_bits < 16'd2) begin
      sts.fmt_code = wsp_pkg::ERR_BITS_LOW;
    end else if (f_bits > 16'd64) begin
      sts.fmt_code = wsp_pkg::ERR_BITS_HIGH;
    end else if (f_bits_rnd != {1'b0, f_align}) begin
      sts.fmt_code = wsp_pkg::ERR_ALIGN_MISM;
    end else begin
      sts.fmt_code = wsp_pkg::ERR_RIFF_ID;
      sts.fmt_bad  = 1'b0;
    end
  end

  // header, chunk and format registers
  always_comb begin
    cnt_nxt   = cnt_e;
    word_nxt  = word_r;
    id_nxt    = id_r;
    skip_nxt  = skip_r;
    seen_nxt  = cmd.restart ? 1'b0 : seen_r;
    rate_nxt  = rate_e;
    bits_nxt  = bits_e;
    bytes_nxt = bytes_e;
    if (cmd.shift_word) begin
      word_nxt = word_new;
      cnt_nxt  = sts.word_last ? 4'd0 : cnt_e + 4'd1;
    end
    if (cmd.fmt_write) begin
      cnt_nxt = cnt_e + 4'd1;
    end
    if (cmd.latch_id) begin
      id_nxt = word_new;
    end
    if (cmd.load_skip_fmt) begin
      skip_nxt = (padded > 32'd16) ? padded - 32'd16 : 32'd0;
    end
    if (cmd.load_skip_pad) begin
      skip_nxt = padded;
    end
    if (cmd.skip_dec) begin
      skip_nxt = skip_r - 32'd1;
    end
    if (cmd.fmt_commit) begin
      seen_nxt  = 1'b1;
      rate_nxt  = f_rate;
      bits_nxt  = f_bits[6:0];
      bytes_nxt = f_align[3:0];
    end
  end

  // sample assembly
  always_comb begin
    acc_nxt = acc_r;
    idx_nxt = idx_r;
    if (cmd.sample_clear) begin
      acc_nxt = 32'd0;
      idx_nxt = 3'd0;
    end else if (cmd.sample_add) begin
      if (sts.sample_last) begin
        acc_nxt = 32'd0;
        idx_nxt = 3'd0;
      end else begin
        acc_nxt = acc_sum;
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  // restoring divider for the frame count, one quotient bit a cycle
  always_comb begin
    div_try      = {rem_r, dvd_r[31]};
    div_ge       = (div_try >= {1'b0, bytes_r});
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    if (cmd.div_start) begin
      div_busy_nxt = 1'b1;
      div_cnt_nxt  = 5'd0;
      dvd_nxt      = word_new;
      rem_nxt      = 4'd0;
    end else if (div_busy_r) begin
      rem_nxt     = div_ge ? (div_try[3:0] - bytes_r) : div_try[3:0];
      dvd_nxt     = {dvd_r[30:0], div_ge};
      div_cnt_nxt = div_cnt_r + 5'd1;
      if (div_cnt_r == 5'd31) begin
        div_busy_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= 4'd0;
      seen_r     <= 1'b0;
      rate_r     <= 32'd0;
      bits_r     <= 7'd0;
      bytes_r    <= 4'd0;
      div_busy_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      seen_r     <= seen_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      bytes_r    <= bytes_nxt;
      div_busy_r <= div_busy_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    id_r      <= id_nxt;
    skip_r    <= skip_nxt;
    acc_r     <= acc_nxt;
    idx_r     <= idx_nxt;
    div_cnt_r <= div_cnt_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    if (cmd.fmt_write) begin
      body_r[cnt_e] <= data_byte;
    end
  end

  // result register, format as it stands after this beat
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_kind   <= cmd.out_kind;
      o_sample <= (cmd.out_kind == wsp_pkg::KIND_SAMPLE) ? acc_sum : 32'd0;
      o_rate   <= rate_nxt;
      o_bits   <= bits_nxt;
      o_bytes  <= bytes_nxt;
      o_frames <= (cmd.out_kind == wsp_pkg::KIND_FORMAT) ? dvd_r : 32'd0;
      o_err    <= (cmd.out_kind == wsp_pkg::KIND_ERROR) ? cmd.out_err : wsp_pkg::ERR_RIFF_ID;
    end
  end

endmodule
`default_nettype wire

// ===== design/wsp_ctrl.sv =====
`default_nettype none
module wsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          beat,
  input  wire logic          restart,
  input  wire logic          eos,
  input  wire logic          out_ready,
  input  wire wsp_pkg::sts_t sts,
  output wsp_pkg::cmd_t      cmd,
  output logic               in_ready,
  output logic               out_valid
);

  wsp_pkg::phase_t phase_r, phase_nxt, phase_e;
  logic            eos_r, eos_nxt;
  logic            valid_r, valid_nxt;
  logic            raise, emit, defer;
  wsp_pkg::err_t   code;
  wsp_pkg::kind_t  emit_kind;
  logic            out_free;

  assign out_free  = !valid_r || out_ready;
  assign in_ready  = (phase_r != wsp_pkg::PH_DIV) && out_free;
  assign out_valid = valid_r;
  assign phase_e   = (beat && restart) ? wsp_pkg::PH_RIFF_ID : phase_r;

  // next phase and datapath commands
  always_comb begin
    cmd         = '0;
    cmd.restart = beat && restart;
    phase_nxt   = phase_e;
    eos_nxt     = eos_r;
    raise       = 1'b0;
    emit        = 1'b0;
    defer       = 1'b0;
    code        = wsp_pkg::ERR_RIFF_ID;
    emit_kind   = wsp_pkg::KIND_SAMPLE;
    if (beat) begin
      case (phase_e)
        wsp_pkg::PH_RIFF_ID: begin
          cmd.shift_word = 1'b1;
          if (sts.word_last) begin
            if (!sts.is_riff) begin
              raise = 1'b1;
              code  = wsp_pkg::ERR_RIFF_ID;
            end else begin
              phase_nxt = wsp_pkg::PH_RIFF_SIZE;
            end
          end
        end
        wsp_pkg::PH_RIFF_SIZE: begin
          cmd.shift_word = 1'b1;
          if (sts.word_last) phase_nxt = wsp_pkg::PH_RIFF_TYPE;
        end
        wsp_pkg::PH_RIFF_TYPE: begin
          cmd.shift_word = 1'b1;
          if (sts.word_last) begin
            if (!sts.is_wave) begin
              raise = 1'b1;
              code  = wsp_pkg::ERR_TYPE;
            end else begin
              phase_nxt = wsp_pkg::PH_CHUNK_ID;
            end
          end
        end
        wsp_pkg::PH_CHUNK_ID: begin
          cmd.shift_word = 1'b1;
          if (sts.word_last) begin
            cmd.latch_id = 1'b1;
            phase_nxt    = wsp_pkg::PH_CHUNK_SZ;
          end
        end
        wsp_pkg::PH_CHUNK_SZ: begin
          cmd.shift_word = 1'b1;
          if (sts.word_last) begin
            if (sts.id_fmt) begin
              cmd.load_skip_fmt = 1'b1;
              phase_nxt         = wsp_pkg::PH_FMT_BODY;
            end else if (sts.id_data) begin
              if (!sts.format_seen) begin
                raise = 1'b1;
                code  = wsp_pkg::ERR_DATA_EARLY;
              end else begin
                cmd.div_start = 1'b1;
                defer         = 1'b1;
                eos_nxt       = eos;
                phase_nxt     = wsp_pkg::PH_DIV;
              end
            end else if (sts.padded_zero) begin
              phase_nxt = wsp_pkg::PH_CHUNK_ID;
            end else begin
              cmd.load_skip_pad = 1'b1;
              phase_nxt         = wsp_pkg::PH_SKIP;
            end
          end
        end
        wsp_pkg::PH_FMT_BODY: begin
          cmd.fmt_write = 1'b1;
          if (sts.fmt_last) begin
            if (sts.fmt_bad) begin
              raise = 1'b1;
              code  = sts.fmt_code;
            end else begin
              cmd.fmt_commit = 1'b1;
              phase_nxt = sts.skip_zero ? wsp_pkg::PH_CHUNK_ID : wsp_pkg::PH_SKIP;
            end
          end
        end
        wsp_pkg::PH_SKIP: begin
          cmd.skip_dec = 1'b1;
          if (sts.skip_last) phase_nxt = wsp_pkg::PH_CHUNK_ID;
        end
        wsp_pkg::PH_SAMPLES: begin
          cmd.sample_add = 1'b1;
          if (sts.sample_last) begin
            emit      = 1'b1;
            emit_kind = wsp_pkg::KIND_SAMPLE;
          end
        end
        default: begin
          defer = 1'b1;
        end
      endcase
      // last byte of the file
      if (eos && !defer && !raise) begin
        if (emit) begin
          phase_nxt = wsp_pkg::PH_DONE;
        end else begin
          raise = 1'b1;
          code  = wsp_pkg::ERR_TRUNCATED;
        end
      end
    end else if (phase_r == wsp_pkg::PH_DIV && sts.div_idle && out_free) begin
      // frame count ready
      if (!sts.div_rem_zero) begin
        raise = 1'b1;
        code  = wsp_pkg::ERR_SIZE_MULT;
      end else begin
        emit             = 1'b1;
        emit_kind        = wsp_pkg::KIND_FORMAT;
        cmd.sample_clear = 1'b1;
        phase_nxt        = eos_r ? wsp_pkg::PH_DONE : wsp_pkg::PH_SAMPLES;
      end
    end
    if (raise) begin
      phase_nxt    = wsp_pkg::PH_ERROR;
      cmd.out_load = 1'b1;
      cmd.out_kind = wsp_pkg::KIND_ERROR;
      cmd.out_err  = code;
    end else if (emit) begin
      cmd.out_load = 1'b1;
      cmd.out_kind = emit_kind;
    end
    valid_nxt = cmd.out_load || (valid_r && !out_ready);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsp_pkg::PH_RIFF_ID;
      eos_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      eos_r   <= eos_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/wav_stream_parser.sv =====
// Mono PCM WAV stream parser.
// in_ch carries one file byte per beat, with restart on the first byte of a
// file and end_of_stream on the last. out_ch carries at most one result per
// input beat: the format with frame count when the data chunk opens, then one
// sample per sample_bytes bytes, or an error code that holds until restart.
// A byte is taken each cycle while no divide runs and out_ch is not stalled;
// the result of a beat is registered and shows on out_ch the next cycle.
// The data chunk size is divided by the block align in a restoring divider,
// one quotient bit per cycle; no byte is taken until the format result loads.
// While a result waits on out_ch, in_ch still takes a beat in the cycle that
// out_ch.ready is high; with out_ch stalled, in_ch.ready drops.
// After reset the parser expects the RIFF identifier and holds no format.
// Bytes after the last byte of a file or after an error are dropped until a
// beat with restart.
`default_nettype none
module wav_stream_parser (
  input wire logic clk,
  input wire logic rst_n,
  wsp_in_if.sink   in_ch,
  wsp_out_if.source out_ch
);

  wsp_pkg::cmd_t cmd;
  wsp_pkg::sts_t sts;
  logic          beat;

  assign beat = in_ch.valid && in_ch.ready;

  // sequencer
  wsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .restart   (in_ch.restart),
    .eos       (in_ch.end_of_stream),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  // field registers, divider and result register
  wsp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_ch.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .o_kind    (out_ch.kind),
    .o_sample  (out_ch.sample),
    .o_rate    (out_ch.sample_rate),
    .o_bits    (out_ch.valid_bits),
    .o_bytes   (out_ch.sample_bytes),
    .o_frames  (out_ch.frame_count),
    .o_err     (out_ch.error_code)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // input stalls while the frame count is being divided
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !in_ch.ready)
    else $error("input taken during divide");

  // error results carry no sample and no frame count
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == wsp_pkg::KIND_ERROR) |->
      (out_ch.sample == 32'sd0 && out_ch.frame_count == 32'd0))
    else $error("error result with payload");

endmodule
`default_nettype wire

// ===== tb/wav_stream_parser_tb.sv =====
`default_nettype none
module wav_stream_parser_tb;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       eos;
  } byte_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample;
    logic [31:0] sample_rate;
    logic [6:0]  valid_bits;
    logic [3:0]  sample_bytes;
    logic [31:0] frame_count;
    logic [3:0]  error_code;
  } wav_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsp_in_if  in_ch ();
  wsp_out_if out_ch ();

  wav_stream_parser DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  byte_beat_t  pending_bytes[$];
  wav_result_t expected_results[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_send = 1'b0;
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          files_built = 0;

  // parser state mirror
  wsp_pkg::phase_t pm_phase;
  int unsigned pm_cnt;
  logic [31:0] pm_word;
  logic [31:0] pm_id;
  logic [31:0] pm_skip;
  logic [7:0]  pm_fmt[16];
  bit          pm_fmt_ok;
  logic [31:0] pm_rate;
  logic [6:0]  pm_bits;
  logic [3:0]  pm_bytes;
  logic [31:0] pm_acc;
  logic [2:0]  pm_idx;

  task automatic parser_clear();
    pm_phase = wsp_pkg::PH_RIFF_ID;
    pm_cnt = 0; pm_word = '0; pm_id = '0; pm_skip = '0;
    foreach (pm_fmt[i]) pm_fmt[i] = 8'h00;
    pm_fmt_ok = 0; pm_rate = '0; pm_bits = '0; pm_bytes = '0; pm_acc = '0; pm_idx = '0;
  endtask

  function automatic wav_result_t make_result(logic [1:0] k, logic [31:0] s,
                                              logic [31:0] f, logic [3:0] e);
    wav_result_t r;
    r.kind = k; r.sample = s; r.sample_rate = pm_rate; r.valid_bits = pm_bits;
    r.sample_bytes = pm_bytes; r.frame_count = f; r.error_code = e;
    return r;
  endfunction

  // one byte through the parser mirror; queues the result it makes
  task automatic parse_byte(input byte_beat_t bb);
    bit          got;
    wav_result_t res;
    logic [31:0] w, padded, comp, chans, align, bits, v;
    int          code;
    int unsigned idx;
    bit          last;
    got = 0;
    if (bb.restart) parser_clear();
    if (pm_phase == wsp_pkg::PH_ERROR || pm_phase == wsp_pkg::PH_DONE) return;
    if (pm_phase <= wsp_pkg::PH_CHUNK_SZ) begin
      pm_word = {bb.data_byte, pm_word[31:8]};
      pm_cnt++;
      if (pm_cnt == 4) begin
        pm_cnt = 0;
        w = pm_word;
        case (pm_phase)
          wsp_pkg::PH_RIFF_ID: begin
            if (w != wsp_pkg::ID_RIFF) begin
              res = make_result(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_RIFF_ID);
              got = 1; pm_phase = wsp_pkg::PH_ERROR;
            end else pm_phase = wsp_pkg::PH_RIFF_SIZE;
          end
          wsp_pkg::PH_RIFF_SIZE: pm_phase = wsp_pkg::PH_RIFF_TYPE;
          wsp_pkg::PH_RIFF_TYPE: begin
            if (w != wsp_pkg::ID_WAVE) begin
              res = make_result(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_TYPE);
              got = 1; pm_phase = wsp_pkg::PH_ERROR;
            end else pm_phase = wsp_pkg::PH_CHUNK_ID;
          end
          wsp_pkg::PH_CHUNK_ID: begin
            pm_id = w; pm_phase = wsp_pkg::PH_CHUNK_SZ;
          end
          default: begin
            padded = w + {31'd0, w[0]};
            if (pm_id == wsp_pkg::ID_FMT) begin
              pm_skip = (padded > 16) ? padded - 32'd16 : 32'd0;
              pm_phase = wsp_pkg::PH_FMT_BODY;
            end else if (pm_id == wsp_pkg::ID_DATA) begin
              if (!pm_fmt_ok || pm_bytes == 0) begin
                res = make_result(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_DATA_EARLY);
                got = 1; pm_phase = wsp_pkg::PH_ERROR;
              end else if (w % pm_bytes != 0) begin
                res = make_result(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_SIZE_MULT);
                got = 1; pm_phase = wsp_pkg::PH_ERROR;
              end else begin
                pm_phase = wsp_pkg::PH_SAMPLES; pm_acc = '0; pm_idx = '0;
                res = make_result(wsp_pkg::KIND_FORMAT, '0, w / pm_bytes, '0); got = 1;
              end
            end else if (padded == 0) begin
              pm_phase = wsp_pkg::PH_CHUNK_ID; pm_cnt = 0;
            end else begin
              pm_skip = padded; pm_phase = wsp_pkg::PH_SKIP;
            end
          end
        endcase
      end
    end else if (pm_phase == wsp_pkg::PH_FMT_BODY) begin
      pm_fmt[pm_cnt[3:0]] = bb.data_byte;
      pm_cnt++;
      if (pm_cnt == 16) begin
        pm_cnt = 0;
        comp = {16'd0, pm_fmt[1], pm_fmt[0]};
        chans = {16'd0, pm_fmt[3], pm_fmt[2]};
        align = {16'd0, pm_fmt[13], pm_fmt[12]};
        bits = {16'd0, pm_fmt[15], pm_fmt[14]};
        code = -1;
        if (comp != 1) code = wsp_pkg::ERR_COMP;
        else if (chans == 0) code = wsp_pkg::ERR_ZERO_CHANS;
        else if (chans != 1) code = wsp_pkg::ERR_NOT_MONO;
        else if (align == 0) code = wsp_pkg::ERR_ALIGN_ZERO;
        else if (bits < 2) code = wsp_pkg::ERR_BITS_LOW;
        else if (bits > 64) code = wsp_pkg::ERR_BITS_HIGH;
        else if ((bits + 7) / 8 != align) code = wsp_pkg::ERR_ALIGN_MISM;
        if (code >= 0) begin
          res = make_result(wsp_pkg::KIND_ERROR, '0, '0, code[3:0]);
          got = 1; pm_phase = wsp_pkg::PH_ERROR;
        end else begin
          pm_rate = {pm_fmt[7], pm_fmt[6], pm_fmt[5], pm_fmt[4]};
          pm_bits = bits[6:0]; pm_bytes = align[3:0]; pm_fmt_ok = 1;
          if (pm_skip != 0) pm_phase = wsp_pkg::PH_SKIP;
          else begin pm_phase = wsp_pkg::PH_CHUNK_ID; pm_cnt = 0; end
        end
      end
    end else if (pm_phase == wsp_pkg::PH_SKIP) begin
      pm_skip--;
      if (pm_skip == 0) begin pm_phase = wsp_pkg::PH_CHUNK_ID; pm_cnt = 0; end
    end else if (pm_phase == wsp_pkg::PH_SAMPLES) begin
      idx = pm_idx;
      v = {24'h0, bb.data_byte};
      last = (idx + 1 >= pm_bytes);
      if (last && pm_bytes >= 2 && bb.data_byte[7]) v = v | 32'hFFFFFF00;
      if (idx < 4) pm_acc = pm_acc + (v << (8 * idx));
      if (!last) pm_idx = pm_idx + 3'd1;
      else begin
        res = make_result(wsp_pkg::KIND_SAMPLE, pm_acc, '0, '0); got = 1;
        pm_acc = '0; pm_idx = '0;
      end
    end
    if (bb.eos && pm_phase != wsp_pkg::PH_ERROR) begin
      if (!got) begin
        res = make_result(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_TRUNCATED);
        got = 1; pm_phase = wsp_pkg::PH_ERROR;
      end else pm_phase = wsp_pkg::PH_DONE;
    end
    if (got) expected_results.push_back(res);
  endtask

  // stimulus builders
  logic [7:0] file_bytes[$];

  task automatic put32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_fmt(input int align, input int bits, input logic [31:0] rate,
                         input int extra, input logic [15:0] comp, input logic [15:0] chans);
    put32(wsp_pkg::ID_FMT);
    put32(16 + extra);
    put32({chans, comp});
    put32(rate);
    put32($urandom);
    put32({bits[15:0], align[15:0]});
    for (int i = 0; i < extra + (extra & 1); i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic queue_file(input int truncate_at, input bit with_eos);
    int n;
    byte_beat_t bb;
    n = file_bytes.size();
    if (truncate_at >= 0 && truncate_at < n) n = truncate_at;
    for (int i = 0; i < n; i++) begin
      bb.data_byte = file_bytes[i];
      bb.restart = (i == 0);
      bb.eos = with_eos && (i == n - 1);
      pending_bytes.push_back(bb);
    end
    file_bytes.delete();
    files_built++;
  endtask

  task automatic build_wav(input int align, input int bits, input int frames,
                           input bit add_junk);
    put32(wsp_pkg::ID_RIFF); put32($urandom); put32(wsp_pkg::ID_WAVE);
    if (add_junk) begin
      int sz;
      sz = $urandom_range(0, 7);
      put32($urandom | 32'h1); put32(sz);
      for (int i = 0; i < sz + (sz & 1); i++) file_bytes.push_back(8'($urandom));
    end
    put_fmt(align, bits, $urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0,
            16'd1, 16'd1);
    put32(wsp_pkg::ID_DATA); put32(frames * align);
    for (int i = 0; i < frames * align; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // accepted input beat, seen by the driver at the next falling edge
  bit in_fire;
  always @(posedge clk) in_fire <= in_ch.valid && in_ch.ready && rst_n;

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'h00;
      in_ch.restart <= 1'b0;
      in_ch.end_of_stream <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_fire) begin
        parse_byte(pending_bytes.pop_front());
        bytes_sent++;
      end
      if (pending_bytes.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= pending_bytes[0].data_byte;
        in_ch.restart <= pending_bytes[0].restart;
        in_ch.end_of_stream <= pending_bytes[0].eos;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    wav_result_t act, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act.kind = out_ch.kind; act.sample = out_ch.sample;
      act.sample_rate = out_ch.sample_rate; act.valid_bits = out_ch.valid_bits;
      act.sample_bytes = out_ch.sample_bytes; act.frame_count = out_ch.frame_count;
      act.error_code = out_ch.error_code;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat kind=%0d", act.kind);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (act.kind != exp_r.kind) begin
          $error("kind: expected %0d got %0d", exp_r.kind, act.kind); fail_count++;
        end
        if (act.sample != exp_r.sample) begin
          $error("sample: expected %h got %h", exp_r.sample, act.sample); fail_count++;
        end
        if (act.sample_rate != exp_r.sample_rate) begin
          $error("sample_rate: expected %h got %h", exp_r.sample_rate, act.sample_rate);
          fail_count++;
        end
        if (act.valid_bits != exp_r.valid_bits) begin
          $error("valid_bits: expected %0d got %0d", exp_r.valid_bits, act.valid_bits);
          fail_count++;
        end
        if (act.sample_bytes != exp_r.sample_bytes) begin
          $error("sample_bytes: expected %0d got %0d", exp_r.sample_bytes, act.sample_bytes);
          fail_count++;
        end
        if (act.frame_count != exp_r.frame_count) begin
          $error("frame_count: expected %0d got %0d", exp_r.frame_count, act.frame_count);
          fail_count++;
        end
        if (act.error_code != exp_r.error_code) begin
          $error("error_code: expected %0d got %0d", exp_r.error_code, act.error_code);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int sel, al, bt;
    parser_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes of format, each error, edge sizes
    build_wav(1, 8, 3, 0); file_bytes[$] = 8'hFF; queue_file(-1, 1);
    build_wav(2, 16, 2, 1); queue_file(-1, 0);
    build_wav(4, 32, 2, 0); queue_file(-1, 1);
    build_wav(8, 64, 2, 0); queue_file(-1, 1);
    build_wav(1, 2, 2, 0); queue_file(-1, 1);
    build_wav(3, 24, 2, 0); queue_file(-1, 1);
    put32(32'h46464953); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(32'h0); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(2, 16, 0, 0, 16'd3, 16'd1); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(2, 16, 0, 0, 16'd1, 16'd0); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(2, 16, 0, 0, 16'd1, 16'd2); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(0, 16, 0, 0, 16'd1, 16'd1); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(1, 1, 0, 0, 16'd1, 16'd1); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(9, 65, 0, 0, 16'd1, 16'd1); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(3, 16, 0, 0, 16'd1, 16'd1); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put32(wsp_pkg::ID_DATA); put32(4); queue_file(-1, 0);
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put_fmt(2, 16, 32'hFFFFFFFF, 0, 16'd1, 16'd1);
    put32(wsp_pkg::ID_DATA); put32(5); queue_file(-1, 0);
    // odd all-ones size skips nothing, then a repeated fmt
    put32(wsp_pkg::ID_RIFF); put32(0); put32(wsp_pkg::ID_WAVE);
    put32(32'h4B4E554A); put32(32'hFFFFFFFF);
    put_fmt(1, 8, 8000, 0, 16'd1, 16'd1); put_fmt(2, 12, 44100, 1, 16'd1, 16'd1);
    put32(wsp_pkg::ID_DATA); put32(32'hFFFFFFFE);
    for (int i = 0; i < 6; i++) file_bytes.push_back(8'($urandom));
    queue_file(-1, 1);
    build_wav(2, 16, 3, 0); queue_file(20, 1);
    build_wav(2, 16, 3, 0); queue_file(-1, 0);
    for (int i = 0; i < 5; i++) pending_bytes.push_back('{8'hA5, 1'b0, 1'b1});
    wait_drained();

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 75 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 75 : 0;
      if (ph == 3) begin send_idle_pct = 6; recv_stall_pct = 6; end
      for (int f = 0; f < 4; f++) begin
        sel = $urandom_range(0, 9);
        al = $urandom_range(1, 8);
        bt = $urandom_range(al * 8 - 7 < 2 ? 2 : al * 8 - 7, al * 8);
        build_wav(al, bt, $urandom_range(0, 12), $urandom_range(0, 1));
        if (sel == 0) queue_file($urandom_range(1, 60), 1);
        else if (sel == 1) begin
          for (int i = 0; i < file_bytes.size(); i++)
            if ($urandom_range(0, 40) == 0) file_bytes[i] = 8'($urandom);
          queue_file(-1, $urandom_range(0, 1));
        end else queue_file(-1, (sel != 2));
        if (sel == 3) for (int i = 0; i < 3; i++)
          pending_bytes.push_back('{8'($urandom), 1'b0, 1'($urandom_range(0, 1))});
        if (f == 2 && ph == 1) begin
          while (pending_bytes.size() != 0) @(posedge clk);
          hold_send = 1'b1;
          while (expected_results.size() != 0) @(posedge clk);
          repeat (40) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      wait_drained();
    end

    $display("covered %0d files, %0d byte beats, %0d result beats", files_built, bytes_sent,
             results_seen);
    $display("formats 1..8 bytes, every error code, truncation, skips, idle and stall mixes");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
